[rtl/core/brl_pkg.sv]
// Package: shared constants, types and helpers for the breathing RGB LED PWM core.
`timescale 1ns / 1ps

package brl_pkg;

  localparam int unsigned ADDR_W  = 4;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned BCOUNT_W = 19;
  localparam int unsigned RAMP_W   = 8;
  localparam int unsigned BRIGHT_W = 7;
  localparam int unsigned PROD_W   = 23;

  typedef enum logic [1:0] {
    REG_COLOR_CODE    = 2'd0,
    REG_BREATH_PERIOD = 2'd1,
    REG_PWM_PERIOD    = 2'd2
  } reg_idx_t;

  localparam logic [COLOR_W-1:0]  COLOR_RED   = 8'd82;  // 'R'
  localparam logic [COLOR_W-1:0]  COLOR_GREEN = 8'd71;  // 'G'
  localparam logic [COLOR_W-1:0]  COLOR_BLUE  = 8'd66;  // 'B'
  localparam logic [COLOR_W-1:0]  COLOR_WHITE = 8'd87;  // 'W'

  localparam logic [COLOR_W-1:0]  COLOR_CODE_RST    = COLOR_WHITE;
  localparam logic [PERIOD_W-1:0] BREATH_PERIOD_RST = 16'd0;
  localparam logic [PERIOD_W-1:0] PWM_PERIOD_RST    = 16'd2000;

  localparam logic [RAMP_W-1:0]   RAMP_WRAP   = 8'd200;
  localparam logic [RAMP_W-1:0]   RAMP_HALF   = 8'd100;
  localparam logic [PROD_W-1:0]   PERCENT_MUL = 23'd100;

  // pin_state: bit0 red, bit1 green, bit2 blue, bit3 on phase
  typedef logic [3:0] pins_t;

  function automatic logic [2:0] color_pins(input logic [COLOR_W-1:0] code);
    logic [2:0] pins;
    unique case (code)
      COLOR_RED:   pins = 3'b001;
      COLOR_GREEN: pins = 3'b010;
      COLOR_BLUE:  pins = 3'b100;
      COLOR_WHITE: pins = 3'b111;
      default:     pins = 3'b000;
    endcase
    return pins;
  endfunction

  // triangle fold of the 0..199 ramp into 0..100 percent
  function automatic logic [BRIGHT_W-1:0] ramp_fold(input logic [RAMP_W-1:0] ramp);
    logic [RAMP_W-1:0] folded;
    folded = (ramp >= RAMP_HALF) ? (RAMP_WRAP - ramp) : ramp;
    return folded[BRIGHT_W-1:0];
  endfunction

endpackage

[rtl/core/brl_tick_if.sv]
// Interface: tick input channel (valid/ready with PWM and breathing ticks).
`timescale 1ns / 1ps

interface brl_tick_if;
  logic valid;
  logic ready;
  logic pwm_tick;
  logic breath_tick;

  modport source (output valid, output pwm_tick, output breath_tick, input ready);
  modport sink   (input valid, input pwm_tick, input breath_tick, output ready);
endinterface

[rtl/core/brl_led_if.sv]
// Interface: LED result channel (valid/ready with pin drives and brightness).
`timescale 1ns / 1ps

interface brl_led_if;
  logic       valid;
  logic       ready;
  logic       red_on;
  logic       green_on;
  logic       blue_on;
  logic       led_active;
  logic [6:0] brightness_now;

  modport source (output valid, output red_on, output green_on, output blue_on,
                  output led_active, output brightness_now, input ready);
  modport sink   (input valid, input red_on, input green_on, input blue_on,
                  input led_active, input brightness_now, output ready);
endinterface

[rtl/core/breathing_rgb_led_pwm_core.sv]
// Top level: breathing RGB LED PWM core with APB configuration.
//
//   channel  dir  handshake      payload
//   ticks    in   valid/ready    pwm_tick, breath_tick
//   leds     out  valid/ready    red_on, green_on, blue_on, led_active, brightness_now
//   apb      in   psel/penable   color_code @0x0, breath_period_ms @0x4, pwm_period_ticks @0x8
//
// One transfer per cycle unless the output stalls; the result appears in the next cycle.
// Path per cycle: ramp fold, one 7x16 multiply and a 23-bit compare.
// The output register holds the result; a new input is taken whenever it is empty or drained.
// rst is synchronous; after reset the core accepts input on the next cycle.
`timescale 1ns / 1ps

module breathing_rgb_led_pwm_core (
  input  logic                         clk,
  input  logic                         rst,
  brl_tick_if.sink                     ticks,
  brl_led_if.source                    leds,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [brl_pkg::ADDR_W-1:0]   paddr,
  input  logic [brl_pkg::DATA_W-1:0]   pwdata,
  output logic [brl_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  logic [brl_pkg::COLOR_W-1:0]  color_code;
  logic [brl_pkg::PERIOD_W-1:0] breath_period_ms;
  logic [brl_pkg::PERIOD_W-1:0] pwm_period_ticks;

  logic [brl_pkg::PERIOD_W-1:0] pwm_count, pwm_count_next;
  logic [brl_pkg::BCOUNT_W-1:0] breath_count, breath_count_next;
  logic [brl_pkg::RAMP_W-1:0]   ramp_step, ramp_step_next;
  logic [brl_pkg::BRIGHT_W-1:0] brightness, brightness_next;
  brl_pkg::pins_t               pin_state, pin_state_next;
  logic                         out_valid;

  logic                         accept;
  logic                         cfg_write;
  logic [brl_pkg::BCOUNT_W-1:0] breath_limit;
  logic [brl_pkg::BCOUNT_W-1:0] breath_count_inc;
  logic [brl_pkg::RAMP_W-1:0]   ramp_inc;
  logic [brl_pkg::PERIOD_W-1:0] pwm_count_inc;
  logic [brl_pkg::PROD_W-1:0]   count_scaled;
  logic [brl_pkg::PROD_W-1:0]   on_bound;
  logic                         pwm_on;

  // configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_code       <= brl_pkg::COLOR_CODE_RST;
      breath_period_ms <= brl_pkg::BREATH_PERIOD_RST;
      pwm_period_ticks <= brl_pkg::PWM_PERIOD_RST;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        brl_pkg::REG_COLOR_CODE:    color_code       <= pwdata[brl_pkg::COLOR_W-1:0];
        brl_pkg::REG_BREATH_PERIOD: breath_period_ms <= pwdata[brl_pkg::PERIOD_W-1:0];
        brl_pkg::REG_PWM_PERIOD:    pwm_period_ticks <= pwdata[brl_pkg::PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      brl_pkg::REG_COLOR_CODE:    prdata = {24'd0, color_code};
      brl_pkg::REG_BREATH_PERIOD: prdata = {16'd0, breath_period_ms};
      brl_pkg::REG_PWM_PERIOD:    prdata = {16'd0, pwm_period_ticks};
      default:                    prdata = '0;
    endcase
  end

  // handshake
  assign ticks.ready = !out_valid || leds.ready;
  assign accept      = ticks.valid && ticks.ready;

  // breathing prescaler and ramp
  assign breath_limit     = {1'b0, breath_period_ms, 2'b00} + {3'b000, breath_period_ms};
  assign breath_count_inc = breath_count + 19'd1;
  assign ramp_inc         = ramp_step + 8'd1;

  always_comb begin
    breath_count_next = breath_count;
    ramp_step_next    = ramp_step;
    brightness_next   = brightness;
    if (ticks.breath_tick) begin
      if (breath_count_inc >= breath_limit) begin
        breath_count_next = '0;
        ramp_step_next    = (ramp_inc >= brl_pkg::RAMP_WRAP) ? '0 : ramp_inc;
      end else begin
        breath_count_next = breath_count_inc;
      end
      brightness_next = brl_pkg::ramp_fold(ramp_step_next);
    end
  end

  // PWM: count <= floor(b*P/100)  <=>  100*count <= b*P
  assign pwm_count_inc = pwm_count + 16'd1;
  assign count_scaled  = {7'd0, pwm_count_inc} * brl_pkg::PERCENT_MUL;
  assign on_bound      = {16'd0, brightness_next} * {7'd0, pwm_period_ticks};
  assign pwm_on        = count_scaled <= on_bound;

  always_comb begin
    pwm_count_next = pwm_count;
    pin_state_next = pin_state;
    if (ticks.pwm_tick) begin
      pin_state_next = pwm_on ? {1'b1, brl_pkg::color_pins(color_code)} : 4'b0000;
      pwm_count_next = (pwm_count_inc >= pwm_period_ticks) ? '0 : pwm_count_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pwm_count    <= '0;
      breath_count <= '0;
      ramp_step    <= '0;
      brightness   <= '0;
      pin_state    <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        pwm_count    <= pwm_count_next;
        breath_count <= breath_count_next;
        ramp_step    <= ramp_step_next;
        brightness   <= brightness_next;
        pin_state    <= pin_state_next;
        out_valid    <= 1'b1;
      end else if (leds.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign leds.valid          = out_valid;
  assign leds.red_on         = pin_state[0];
  assign leds.green_on       = pin_state[1];
  assign leds.blue_on        = pin_state[2];
  assign leds.led_active     = pin_state[3];
  assign leds.brightness_now = brightness;

`ifndef SYNTHESIS
  a_ramp_range: assert property (@(posedge clk) disable iff (rst)
    ramp_step < brl_pkg::RAMP_WRAP)
    else $error("ramp out of range");

  a_bright_fold: assert property (@(posedge clk) disable iff (rst)
    brightness == brl_pkg::ramp_fold(ramp_step))
    else $error("brightness does not match ramp");

  a_dark_off: assert property (@(posedge clk) disable iff (rst)
    !pin_state[3] |-> (pin_state[2:0] == 3'b000))
    else $error("pin lit outside on phase");

  a_no_pwm_hold: assert property (@(posedge clk) disable iff (rst)
    (accept && !ticks.pwm_tick) |=> ($stable(pin_state) && $stable(pwm_count)))
    else $error("PWM state moved without a PWM tick");
`endif

endmodule

[sim/tb.sv]
// Testbench: breathing RGB LED PWM core checked item by item against a behavioral predictor.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned QUIET_LIMIT = 500;
  localparam int unsigned PRINT_LIMIT = 100;
  localparam int unsigned RAND_PHASES = 16;
  localparam int unsigned PHASE_ITEMS = 120;

  localparam logic [brl_pkg::ADDR_W-1:0] ADDR_COLOR_CODE =
    {brl_pkg::REG_COLOR_CODE, 2'b00};
  localparam logic [brl_pkg::ADDR_W-1:0] ADDR_BREATH_PERIOD =
    {brl_pkg::REG_BREATH_PERIOD, 2'b00};
  localparam logic [brl_pkg::ADDR_W-1:0] ADDR_PWM_PERIOD =
    {brl_pkg::REG_PWM_PERIOD, 2'b00};
  localparam logic [brl_pkg::ADDR_W-1:0] ADDR_UNMAPPED = 4'hC;

  typedef struct packed {
    logic                         red;
    logic                         green;
    logic                         blue;
    logic                         active;
    logic [brl_pkg::BRIGHT_W-1:0] bright;
  } led_drive_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [brl_pkg::ADDR_W-1:0] paddr;
  logic [brl_pkg::DATA_W-1:0] pwdata;
  logic [brl_pkg::DATA_W-1:0] prdata;
  logic                       pready;

  brl_tick_if tick_ch ();
  brl_led_if  led_ch ();

  breathing_rgb_led_pwm_core dut (
    .clk     (clk),
    .rst     (rst),
    .ticks   (tick_ch),
    .leds    (led_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predictor state and register copies
  logic [brl_pkg::COLOR_W-1:0]  cfg_color;
  logic [brl_pkg::PERIOD_W-1:0] cfg_breath_period;
  logic [brl_pkg::PERIOD_W-1:0] cfg_pwm_period;
  logic [brl_pkg::PERIOD_W-1:0] pwm_cnt;
  logic [brl_pkg::BCOUNT_W-1:0] breath_cnt;
  logic [brl_pkg::RAMP_W-1:0]   ramp;
  logic [brl_pkg::BRIGHT_W-1:0] bright;
  logic [3:0]                   pins;

  led_drive_t  led_drive_q[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned quiet_cycles;
  bit          sender_gaps;
  bit          sink_stalls;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic report_mismatch(input string msg);
    if (mismatches < PRINT_LIMIT)
      $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  task automatic advance_led_drive(input logic pwm, input logic brth, output led_drive_t drv);
    logic [brl_pkg::BCOUNT_W-1:0] breath_limit;
    logic [brl_pkg::PROD_W-1:0]   on_limit;
    if (brth) begin
      breath_limit = brl_pkg::BCOUNT_W'(cfg_breath_period) * brl_pkg::BCOUNT_W'(5);
      breath_cnt = breath_cnt + 19'd1;
      if (breath_cnt >= breath_limit) begin
        breath_cnt = '0;
        ramp = (ramp >= 8'd199) ? 8'd0 : ramp + 8'd1;
      end
      bright = (ramp >= 8'd100) ? brl_pkg::BRIGHT_W'(8'd200 - ramp) :
                                  brl_pkg::BRIGHT_W'(ramp);
    end
    if (pwm) begin
      on_limit = (brl_pkg::PROD_W'(bright) * brl_pkg::PROD_W'(cfg_pwm_period)) /
                 brl_pkg::PROD_W'(100);
      pwm_cnt = pwm_cnt + 16'd1;
      if (brl_pkg::PROD_W'(pwm_cnt) <= on_limit) begin
        case (cfg_color)
          brl_pkg::COLOR_RED:   pins = 4'b1001;
          brl_pkg::COLOR_GREEN: pins = 4'b1010;
          brl_pkg::COLOR_BLUE:  pins = 4'b1100;
          brl_pkg::COLOR_WHITE: pins = 4'b1111;
          default:              pins = 4'b1000;
        endcase
      end else begin
        pins = 4'b0000;
      end
      if (pwm_cnt >= cfg_pwm_period)
        pwm_cnt = '0;
    end
    drv.red    = pins[0];
    drv.green  = pins[1];
    drv.blue   = pins[2];
    drv.active = pins[3];
    drv.bright = bright;
  endtask

  // valid stays high between back-to-back transfers
  task automatic send_ticks(input logic pwm, input logic brth);
    int unsigned gap;
    led_drive_t  drv;
    gap = sender_gaps ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tick_ch.valid       <= 1'b1;
    tick_ch.pwm_tick    <= pwm;
    tick_ch.breath_tick <= brth;
    do @(posedge clk); while (!tick_ch.ready);
    advance_led_drive(pwm, brth, drv);
    led_drive_q.push_back(drv);
  endtask

  task automatic wait_idle();
    tick_ch.valid <= 1'b0;
    while (led_drive_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic apb_write(input logic [brl_pkg::ADDR_W-1:0] addr,
                           input logic [brl_pkg::DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (addr)
      ADDR_COLOR_CODE:    cfg_color = data[brl_pkg::COLOR_W-1:0];
      ADDR_BREATH_PERIOD: cfg_breath_period = data[brl_pkg::PERIOD_W-1:0];
      ADDR_PWM_PERIOD:    cfg_pwm_period = data[brl_pkg::PERIOD_W-1:0];
      default: ;
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_ticks(1'b0, 1'b0);
    send_ticks(1'b1, 1'b0);
    send_ticks(1'b0, 1'b1);
    send_ticks(1'b1, 1'b1);
  endtask

  task automatic test_zero_pwm_period();
    wait_idle();
    apb_write(ADDR_PWM_PERIOD, 32'h0);
    send_ticks(1'b1, 1'b0);
    send_ticks(1'b1, 1'b1);
  endtask

  // new color shows only on the next PWM tick in the on phase
  task automatic test_colors();
    logic [brl_pkg::COLOR_W-1:0] codes[5];
    codes = '{brl_pkg::COLOR_RED, 8'h00, brl_pkg::COLOR_GREEN, brl_pkg::COLOR_BLUE,
              brl_pkg::COLOR_WHITE};
    wait_idle();
    apb_write(ADDR_PWM_PERIOD, 32'd200);
    foreach (codes[i]) begin
      wait_idle();
      apb_write(ADDR_COLOR_CODE, {$urandom} & ~32'hFF | 32'(codes[i]));
      send_ticks(1'b0, 1'b0);
      send_ticks(1'b1, 1'b1);
    end
  endtask

  task automatic test_period_lowered();
    wait_idle();
    apb_write(ADDR_PWM_PERIOD, 32'd3);
    send_ticks(1'b1, 1'b0);
    wait_idle();
    apb_write(ADDR_BREATH_PERIOD, 32'hFFFF_FFFF);
    apb_write(ADDR_PWM_PERIOD, 32'h0000_FFFF);
    apb_write(ADDR_COLOR_CODE, 32'hFF);
    repeat (5) send_ticks(1'b1, 1'b1);
    wait_idle();
    apb_write(ADDR_BREATH_PERIOD, 32'd1);
    send_ticks(1'b0, 1'b1);
  endtask

  task automatic test_unmapped_write();
    wait_idle();
    apb_write(ADDR_UNMAPPED, $urandom);
    send_ticks(1'b1, 1'b1);
  endtask

  task automatic test_random_traffic();
    logic [brl_pkg::COLOR_W-1:0]  color;
    logic [brl_pkg::PERIOD_W-1:0] brth_period;
    logic [brl_pkg::PERIOD_W-1:0] pwm_period;
    int unsigned                  brth_pct;
    int unsigned                  pwm_pct;
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       color = brl_pkg::COLOR_RED;
        1:       color = brl_pkg::COLOR_GREEN;
        2:       color = brl_pkg::COLOR_BLUE;
        3:       color = brl_pkg::COLOR_WHITE;
        default: color = brl_pkg::COLOR_W'($urandom_range(0, 255));
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2: brth_period = '0;
        3:       brth_period = 16'd1;
        4:       brth_period = 16'd2;
        5, 6, 7: brth_period = brl_pkg::PERIOD_W'($urandom_range(3, 12));
        8:       brth_period = 16'hFFFF;
        default: brth_period = brl_pkg::PERIOD_W'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0:       pwm_period = '0;
        1:       pwm_period = 16'd1;
        2:       pwm_period = 16'd2;
        3, 4:    pwm_period = brl_pkg::PERIOD_W'($urandom_range(3, 60));
        5:       pwm_period = brl_pkg::PERIOD_W'($urandom_range(61, 400));
        6:       pwm_period = 16'hFFFF;
        default: pwm_period = brl_pkg::PERIOD_W'($urandom);
      endcase
      wait_idle();
      if ($urandom_range(0, 3) != 0)
        apb_write(ADDR_COLOR_CODE, {$urandom} & ~32'hFF | 32'(color));
      if ($urandom_range(0, 3) != 0)
        apb_write(ADDR_BREATH_PERIOD, {$urandom} & ~32'hFFFF | 32'(brth_period));
      if ($urandom_range(0, 3) != 0)
        apb_write(ADDR_PWM_PERIOD, {$urandom} & ~32'hFFFF | 32'(pwm_period));
      sender_gaps = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      brth_pct = $urandom_range(10, 100);
      pwm_pct  = $urandom_range(30, 100);
      repeat (PHASE_ITEMS)
        send_ticks($urandom_range(1, 100) <= pwm_pct, $urandom_range(1, 100) <= brth_pct);
    end
  endtask

  initial begin
    tick_ch.valid       <= 1'b0;
    tick_ch.pwm_tick    <= 1'b0;
    tick_ch.breath_tick <= 1'b0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    cfg_color         = brl_pkg::COLOR_CODE_RST;
    cfg_breath_period = brl_pkg::BREATH_PERIOD_RST;
    cfg_pwm_period    = brl_pkg::PWM_PERIOD_RST;
    pwm_cnt     = '0;
    breath_cnt  = '0;
    ramp        = '0;
    bright      = '0;
    pins        = '0;
    mismatches  = 0;
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_zero_pwm_period();
    test_colors();
    test_period_lowered();
    test_unmapped_write();
    test_random_traffic();
    wait_idle();
    repeat (3) @(posedge clk);
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  task automatic check_led_drive();
    led_drive_t want;
    results_seen++;
    if (led_drive_q.size() == 0) begin
      report_mismatch($sformatf("result %0d with nothing expected", results_seen));
    end else begin
      want = led_drive_q.pop_front();
      if (led_ch.red_on !== want.red)
        report_mismatch($sformatf("result %0d red_on: got %b, expected %b",
                                  results_seen, led_ch.red_on, want.red));
      if (led_ch.green_on !== want.green)
        report_mismatch($sformatf("result %0d green_on: got %b, expected %b",
                                  results_seen, led_ch.green_on, want.green));
      if (led_ch.blue_on !== want.blue)
        report_mismatch($sformatf("result %0d blue_on: got %b, expected %b",
                                  results_seen, led_ch.blue_on, want.blue));
      if (led_ch.led_active !== want.active)
        report_mismatch($sformatf("result %0d led_active: got %b, expected %b",
                                  results_seen, led_ch.led_active, want.active));
      if (led_ch.brightness_now !== want.bright)
        report_mismatch($sformatf("result %0d brightness_now: got %0d, expected %0d",
                                  results_seen, led_ch.brightness_now, want.bright));
    end
  endtask

  initial begin
    int unsigned stall;
    results_seen = 0;
    led_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = sink_stalls ? $urandom_range(0, 5) : 0;
      if (stall > 0) begin
        led_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      led_ch.ready <= 1'b1;
      do @(posedge clk); while (!led_ch.valid);
      check_led_drive();
    end
  end

  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (led_ch.valid && led_ch.ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
